@@ rtl/core/kms_pkg.sv @@
// ----------------------------------------------------------------------------
// kms_pkg - shared types and codes for the k-way merge select core
// Operation and status codes, payload structs and the scan token.
// ----------------------------------------------------------------------------
package kms_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PUSH  = 2'd1,
    OP_END   = 2'd2,
    OP_POP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REFILL = 2'd1,
    ST_DONE   = 2'd2,
    ST_REJECT = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         run_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] merged_value;
    logic [3:0]         source_run;
    logic               is_last;
  } out_item_t;

  // Token handed from cell to cell during a pop scan.
  typedef struct packed {
    logic               refill;
    logic [3:0]         refill_run;
    logic               found;
    logic [3:0]         best_run;
    logic signed [31:0] best_val;
    logic               busy;
  } scan_t;

endpackage

@@ rtl/core/kms_cell.sv @@
// ----------------------------------------------------------------------------
// kms_cell - one stage of the pop scan chain
// Fold one run's head into the token and register it for the next cell.
// ----------------------------------------------------------------------------
module kms_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              active,
  input  logic              finished,
  input  logic              nonempty,
  input  logic [3:0]        run_id,
  input  logic signed [31:0] head,
  input  kms_pkg::scan_t    tok_i,
  output kms_pkg::scan_t    tok_o
);

  kms_pkg::scan_t tok_nxt, tok_r;

  always_comb begin
    tok_nxt = tok_i;
    if (active) begin
      if (!finished && !nonempty && !tok_i.refill) begin
        tok_nxt.refill     = 1'b1;
        tok_nxt.refill_run = run_id;
      end
      // highest index wins ties: take on less-or-equal
      if (nonempty && (!tok_i.found || head <= tok_i.best_val)) begin
        tok_nxt.found    = 1'b1;
        tok_nxt.best_run = run_id;
        tok_nxt.best_val = head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

@@ rtl/core/kway_merge_select_core.sv @@
// ----------------------------------------------------------------------------
// kway_merge_select_core - selection stage of a k-way merge
// Per-run head FIFOs in one memory, popped through a chain of scan cells.
// ----------------------------------------------------------------------------
//  channel | ports               | transfer
//  input   | in_valid/in_ready   | in_data (kms_pkg::in_item_t)
//  output  | out_valid/out_ready | out_data (kms_pkg::out_item_t)
//  config  | cfg_we/cfg_wdata    | runs_in_use, write only
//
// Clear, push and end_run go from idle through the finish and output states
// back to idle before the next input is taken. A pop passes a scan state first:
// the token walks the cell chain one cell a cycle, each cell reading its run's
// head word from the head memory, one read per cycle on a single port.
// Reset clears pointers, counts and finished flags; head memory is not reset.
// A waiting result is held in the output register; the next item is taken
// once the result register is free.
module kway_merge_select_core #(
  parameter int MAX_RUNS   = 16,
  parameter int HEAD_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kms_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kms_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);

  localparam int NR  = (MAX_RUNS < 16) ? MAX_RUNS : 16;   // runs reachable by 4-bit index
  localparam int RW  = (NR > 1) ? $clog2(NR) : 1;
  localparam int PW  = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
  localparam int CW  = $clog2(HEAD_DEPTH + 1);
  localparam int SW  = $clog2(NR + 2);
  localparam int AW  = ((NR * HEAD_DEPTH) > 1) ? $clog2(NR * HEAD_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_FIN  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0]         runs_r;
  logic [PW-1:0]      rp_r   [NR];
  logic [CW-1:0]      cnt_r  [NR];
  logic [NR-1:0]      fin_r;
  logic signed [31:0] mem    [NR*HEAD_DEPTH];
  logic signed [31:0] rd_q;
  kms_pkg::in_item_t  item_r;
  kms_pkg::out_item_t res_r, res_nxt;
  logic               ov_r;
  logic [SW-1:0]      step_r;
  logic [5:0]         nact;

  assign nact = (runs_r > 5'(NR)) ? 6'(NR) : {1'b0, runs_r};

  // token chain: cell k sees run k; its head read is issued in the step before
  kms_pkg::scan_t tok [NR+1];
  logic adv;
  assign adv = (state_r == S_SCAN);

  assign tok[0] = '0;
  genvar g;
  generate
    for (g = 0; g < NR; g++) begin : g_cell
      logic live;
      assign live = adv && (step_r == SW'(g + 1));
      kms_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (live || (adv && step_r == '0)),
        .active   (live && (6'(g) < nact)),
        .finished (fin_r[g]),
        .nonempty (cnt_r[g] != '0),
        .run_id   (4'(g)),
        .head     (rd_q),
        .tok_i    ((g == 0) ? kms_pkg::scan_t'('0) : tok[g]),
        .tok_o    (tok[g+1])
      );
    end
  endgenerate

  // head memory: one registered read port, one write port
  logic [RW-1:0] rd_run;
  logic          wr_en;
  logic [RW-1:0] wr_run;
  logic [PW-1:0] wr_slot;
  logic [PW+CW-1:0] sum;
  logic [AW-1:0] rd_addr, wr_addr;
  assign rd_run = (step_r < SW'(NR)) ? RW'(step_r) : '0;
  assign wr_run = RW'(item_r.run_index);
  assign sum    = (PW+CW)'(rp_r[wr_run]) + (PW+CW)'(cnt_r[wr_run]);
  // wrap the slot once: the sum stays below twice the depth
  assign wr_slot = (sum >= (PW+CW)'(HEAD_DEPTH)) ? PW'(sum - (PW+CW)'(HEAD_DEPTH)) :
                                                   PW'(sum);
  assign rd_addr = AW'(rd_run) * AW'(HEAD_DEPTH) + AW'(rp_r[rd_run]);
  assign wr_addr = AW'(wr_run) * AW'(HEAD_DEPTH) + AW'(wr_slot);

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= item_r.value;
    end
  end

  // end-of-scan decisions
  kms_pkg::scan_t t;
  logic drained_after;
  always_comb begin
    t = tok[NR];
    drained_after = 1'b1;
    for (int r = 0; r < NR; r++) begin
      if (6'(r) < nact) begin
        if (!fin_r[r]) drained_after = 1'b0;
        if (cnt_r[r] > ((t.found && t.best_run == 4'(r)) ? CW'(1) : CW'(0)))
          drained_after = 1'b0;
      end
    end
  end

  logic push_ok, idx_ok;
  assign idx_ok  = {2'b00, item_r.run_index} < nact;
  assign push_ok = idx_ok && !fin_r[item_r.run_index] &&
                   (cnt_r[item_r.run_index] < CW'(HEAD_DEPTH));
  assign wr_en   = (state_r == S_FIN) && (item_r.operation == kms_pkg::OP_PUSH) && push_ok;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        state_nxt = (in_data.operation == kms_pkg::OP_POP) ? S_SCAN : S_FIN;
      end
      S_SCAN: if (step_r == SW'(NR)) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result of the item in hand
  always_comb begin
    res_nxt = '0;
    case (item_r.operation)
      kms_pkg::OP_CLEAR: begin
        res_nxt.status = kms_pkg::ST_OK;
      end
      kms_pkg::OP_PUSH: begin
        res_nxt.source_run = item_r.run_index;
        if (!push_ok) res_nxt.status = kms_pkg::ST_REJECT;
      end
      kms_pkg::OP_END: begin
        res_nxt.source_run = item_r.run_index;
        if (!idx_ok) res_nxt.status = kms_pkg::ST_REJECT;
      end
      default: begin
        if (t.refill) begin
          res_nxt.status     = kms_pkg::ST_REFILL;
          res_nxt.source_run = t.refill_run;
        end else if (!t.found) begin
          res_nxt.status = kms_pkg::ST_DONE;
        end else begin
          res_nxt.merged_value = t.best_val;
          res_nxt.source_run   = t.best_run;
          res_nxt.is_last      = drained_after;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      runs_r  <= 5'd16;
      fin_r   <= '0;
      ov_r    <= 1'b0;
      step_r  <= '0;
      for (int r = 0; r < NR; r++) begin
        rp_r[r]  <= '0;
        cnt_r[r] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) runs_r <= cfg_wdata;
      if (out_valid && out_ready) ov_r <= 1'b0;
      if (in_valid && in_ready) begin
        item_r <= in_data;
        step_r <= '0;
      end
      if (state_r == S_SCAN) step_r <= step_r + SW'(1);
      if (state_r == S_FIN) begin
        res_r <= res_nxt;
        ov_r  <= 1'b1;
        case (item_r.operation)
          kms_pkg::OP_CLEAR: begin
            fin_r <= '0;
            for (int r = 0; r < NR; r++) begin
              rp_r[r]  <= '0;
              cnt_r[r] <= '0;
            end
          end
          kms_pkg::OP_PUSH: begin
            if (push_ok) cnt_r[item_r.run_index] <= cnt_r[item_r.run_index] + CW'(1);
          end
          kms_pkg::OP_END: begin
            if (idx_ok) fin_r[item_r.run_index] <= 1'b1;
          end
          default: begin
            if (!t.refill && t.found) begin
              // advance the head of the winning run, wrapping at the depth
              rp_r[t.best_run]  <= (rp_r[t.best_run] == PW'(HEAD_DEPTH - 1)) ? '0 :
                                   rp_r[t.best_run] + PW'(1);
              cnt_r[t.best_run] <= cnt_r[t.best_run] - CW'(1);
            end
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/core/kms_checker.sv @@
// ----------------------------------------------------------------------------
// kms_checker - port-level checks for the merge select core
// Handshake and result sanity seen from the ports.
// ----------------------------------------------------------------------------
module kms_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input kms_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result waits");

  a_val_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != kms_pkg::ST_OK |-> out_data.merged_value == 0)
    else $error("value on non-ok result");

  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_last |-> out_data.status == kms_pkg::ST_OK)
    else $error("last flag on failed pop");

endmodule

bind kway_merge_select_core kms_checker u_kms_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
